// ===== src/mfc_pkg.sv =====
// ----------------------------------------------------------------------------
// mfc_pkg
// Shared constants and types for the meter frame checker: flag byte values,
// field widths, status codes and default length limits.
// ----------------------------------------------------------------------------
package mfc_pkg;

   // Field widths of the request and response beats.
   localparam int BYTE_WIDTH   = 8;
   localparam int STATUS_WIDTH = 2;
   localparam int LENGTH_WIDTH = 9;

   // Default frame length limits, in bytes.
   localparam int DEFAULT_MAX_FRAME_LEN = 256;
   localparam int DEFAULT_MIN_FRAME_LEN = 12;

   // Frame delimiters.
   localparam logic [BYTE_WIDTH-1:0] START_FLAG = 8'h68;
   localparam logic [BYTE_WIDTH-1:0] END_FLAG   = 8'h16;

   // Byte positions that must carry the start flag.
   localparam int FIRST_FLAG_POS  = 0;
   localparam int SECOND_FLAG_POS = 7;

   // Frame status codes, in the order the checks are applied.
   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_LENGTH   = 2'd1,
      STATUS_FLAG     = 2'd2,
      STATUS_CHECKSUM = 2'd3
   } frame_status_type;

endpackage

// ===== src/mfc_channels.sv =====
// ----------------------------------------------------------------------------
// mfc_req_if / mfc_rsp_if
// Valid/ready channels of the meter frame checker. A beat moves at a rising
// clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface mfc_req_if;
   logic                             valid;
   logic                             ready;
   logic [mfc_pkg::BYTE_WIDTH-1:0]   frame_byte;
   logic                             end_of_frame;

   modport source (output valid, output frame_byte, output end_of_frame, input ready);
   modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface mfc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mfc_pkg::STATUS_WIDTH-1:0] frame_status;
   logic [mfc_pkg::LENGTH_WIDTH-1:0] frame_length;

   modport source (output valid, output frame_status, output frame_length, input ready);
   modport sink   (input valid, input frame_status, input frame_length, output ready);
endinterface

// ===== src/meter_frame_checker.sv =====
// ----------------------------------------------------------------------------
// meter_frame_checker
// Checks a meter frame arriving one byte per beat. On the final byte it
// reports the frame status (length, flag bytes, checksum) and the length.
// ----------------------------------------------------------------------------
// Throughput: one request beat per cycle while the response register is empty or
// being taken; the count, sum and flag registers update on each accepted beat.
// Response: registered; it appears in the cycle after the final byte is accepted
// and is held in the output register until taken.
// Reset: synchronous; clears the frame state and the response valid.
// ----------------------------------------------------------------------------
module meter_frame_checker #(
   parameter int MAX_FRAME_LEN = mfc_pkg::DEFAULT_MAX_FRAME_LEN,
   parameter int MIN_FRAME_LEN = mfc_pkg::DEFAULT_MIN_FRAME_LEN
) (
   input  logic   clock,
   input  logic   reset,
   mfc_req_if.sink   req_channel,
   mfc_rsp_if.source rsp_channel
);
   import mfc_pkg::*;

   // Count holds up to MAX_FRAME_LEN + 1; the length sum needs one more bit
   // and at least the reported width.
   localparam int CW = $clog2(MAX_FRAME_LEN + 2);
   localparam int LW = (CW + 1 > LENGTH_WIDTH) ? CW + 1 : LENGTH_WIDTH;
   localparam logic [CW-1:0] COUNT_LIMIT = CW'(MAX_FRAME_LEN + 1);
   localparam logic [LW-1:0] LEN_LIMIT   = LW'(MAX_FRAME_LEN + 1);
   localparam logic [LW-1:0] LEN_MAX     = LW'(MAX_FRAME_LEN);
   localparam logic [LW-1:0] LEN_MIN     = LW'(MIN_FRAME_LEN);

   // Frame state.
   logic [CW-1:0]          count_ff, count_in;
   logic [BYTE_WIDTH-1:0]  sum_ff, sum_in;
   logic [BYTE_WIDTH-1:0]  prev_ff, prev_in;
   logic                   first_ok_ff, first_ok_in;
   logic                   second_ok_ff, second_ok_in;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   frame_status_type       status_ff, status_in;
   logic [LENGTH_WIDTH-1:0] length_ff, length_in;

   logic                   req_fire;
   logic [LW-1:0]          len_full;
   logic [LW-1:0]          len_sat;

   // The response register frees up when empty or when its beat is taken.
   assign req_channel.ready = !rsp_valid_ff || rsp_channel.ready;
   assign req_fire          = req_channel.valid && req_channel.ready;

   // Next frame state and the status computed on a final byte.
   always_comb begin
      count_in     = count_ff;
      sum_in       = sum_ff;
      prev_in      = prev_ff;
      first_ok_in  = first_ok_ff;
      second_ok_in = second_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_channel.ready;
      status_in    = status_ff;
      length_in    = length_ff;

      len_full = LW'(count_ff) + LW'(1);
      len_sat  = (len_full > LEN_LIMIT) ? LEN_LIMIT : len_full;

      if (req_fire) begin
         if (req_channel.end_of_frame) begin
            // Checks in priority order; the first failure decides.
            if (len_sat > LEN_MAX || len_sat < LEN_MIN) begin
               status_in = STATUS_LENGTH;
            end else if (!first_ok_ff || !second_ok_ff ||
                         req_channel.frame_byte != END_FLAG) begin
               status_in = STATUS_FLAG;
            end else if (sum_ff != prev_ff) begin
               status_in = STATUS_CHECKSUM;
            end else begin
               status_in = STATUS_OK;
            end
            length_in    = len_sat[LENGTH_WIDTH-1:0];
            rsp_valid_in = 1'b1;
            // Start over for the next frame.
            count_in     = '0;
            sum_in       = '0;
            prev_in      = '0;
            first_ok_in  = 1'b0;
            second_ok_in = 1'b0;
         end else begin
            if (count_ff == CW'(FIRST_FLAG_POS) && req_channel.frame_byte == START_FLAG) begin
               first_ok_in = 1'b1;
            end
            if (count_ff == CW'(SECOND_FLAG_POS) && req_channel.frame_byte == START_FLAG) begin
               second_ok_in = 1'b1;
            end
            // The sum trails by one byte so it never holds the last two bytes.
            if (count_ff != '0) begin
               sum_in = sum_ff + prev_ff;
            end
            prev_in = req_channel.frame_byte;
            if (count_ff < COUNT_LIMIT) begin
               count_in = count_ff + CW'(1);
            end
         end
      end
   end

   // State and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         prev_ff      <= '0;
         first_ok_ff  <= 1'b0;
         second_ok_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         prev_ff      <= prev_in;
         first_ok_ff  <= first_ok_in;
         second_ok_ff <= second_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      length_ff <= length_in;
   end

   assign rsp_channel.valid        = rsp_valid_ff;
   assign rsp_channel.frame_status = status_ff;
   assign rsp_channel.frame_length = length_ff;

   // A final byte always leaves a response waiting in the next cycle.
   a_final_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_channel.end_of_frame |=> rsp_valid_ff)
      else $error("final byte did not produce a response");

   // A final byte clears the frame state.
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_channel.end_of_frame |=>
         count_ff == '0 && sum_ff == '0 && !first_ok_ff && !second_ok_ff)
      else $error("frame state not cleared after final byte");

   // The byte count saturates at one past the maximum length.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_LIMIT)
      else $error("byte count exceeded its limit");

   // A non-final byte never produces a response of its own.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !(req_fire && req_channel.end_of_frame) |=> !rsp_valid_ff)
      else $error("response appeared without a final byte");

endmodule

// ===== tb/meter_frame_checker_tb.sv =====
// ----------------------------------------------------------------------------
// meter_frame_checker_tb
// Drives byte-wide meter frames into the frame checker and compares each
// status beat against a predictor that tracks the byte count, the running
// sum, the last byte and the start-flag marks. About half the frames are well
// formed with random payload. The rest carry checksum or flag faults, bad lengths
// or random noise. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module meter_frame_checker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mfc_pkg::*;

   localparam int MAX_LEN     = DEFAULT_MAX_FRAME_LEN;
   localparam int MIN_LEN     = DEFAULT_MIN_FRAME_LEN;
   localparam int TOTAL_ITEMS = 1100;
   localparam int QUIET_TAIL  = 150;

   typedef logic [BYTE_WIDTH-1:0] frame_bytes_type[$];

   // Predicts the status beat of each frame and checks the ones that arrive.
   class frame_scoreboard;
      typedef struct packed {
         frame_status_type          status;
         logic [LENGTH_WIDTH-1:0]   length;
      } frame_verdict_type;

      frame_verdict_type       verdicts[$];
      int unsigned             byte_count;
      logic [BYTE_WIDTH-1:0]   running_sum;
      logic [BYTE_WIDTH-1:0]   previous_byte;
      bit                      first_flag_ok;
      bit                      second_flag_ok;
      int                      errors;

      function new();
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         byte_count     = 0;
         running_sum    = '0;
         previous_byte  = '0;
         first_flag_ok  = 1'b0;
         second_flag_ok = 1'b0;
      endfunction

      function int outstanding();
         return verdicts.size();
      endfunction

      // Updates the frame state for one accepted request beat.
      function void note_byte(logic [BYTE_WIDTH-1:0] value, logic last);
         int unsigned       len;
         frame_verdict_type v;
         if (!last) begin
            if (byte_count == FIRST_FLAG_POS && value == START_FLAG) first_flag_ok = 1'b1;
            if (byte_count == SECOND_FLAG_POS && value == START_FLAG) second_flag_ok = 1'b1;
            if (byte_count >= 1) running_sum = running_sum + previous_byte;
            previous_byte = value;
            if (byte_count < MAX_LEN + 1) byte_count++;
            return;
         end
         len = byte_count + 1;
         if (len > MAX_LEN + 1) len = MAX_LEN + 1;
         if (len > MAX_LEN || len < MIN_LEN)
            v.status = STATUS_LENGTH;
         else if (!first_flag_ok || !second_flag_ok || value != END_FLAG)
            v.status = STATUS_FLAG;
         else if (running_sum != previous_byte)
            v.status = STATUS_CHECKSUM;
         else
            v.status = STATUS_OK;
         v.length = len[LENGTH_WIDTH-1:0];
         verdicts.push_back(v);
         clear_frame();
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) $display("%t mismatch: %s", $realtime, msg);
      endfunction

      // Compares one response beat with the oldest pending verdict.
      function void check_result(logic [STATUS_WIDTH-1:0] status,
                                 logic [LENGTH_WIDTH-1:0] length);
         frame_verdict_type v;
         if (verdicts.size() == 0) begin
            report($sformatf("unexpected beat status=%0d length=%0d", status, length));
            return;
         end
         v = verdicts.pop_front();
         if (status !== v.status)
            report($sformatf("frame_status expected %0d (%s) got %0d",
                             v.status, v.status.name(), status));
         if (length !== v.length)
            report($sformatf("frame_length expected %0d got %0d", v.length, length));
      endfunction
   endclass

   logic clock;
   logic reset;

   mfc_req_if req_bus ();
   mfc_rsp_if rsp_bus ();

   frame_scoreboard sb = new();

   int items_sent;
   int send_gap_odds;
   int stall_odds;
   int stall_left;

   meter_frame_checker DUT (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_bus.sink),
      .rsp_channel (rsp_bus.source)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Response side: ready drops in random stall bursts when enabled.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left    <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         stall_left    <= $urandom_range(0, 11);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Every accepted response beat is checked.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         sb.check_result(rsp_bus.frame_status, rsp_bus.frame_length);
   end

   // Sends one beat, with an optional idle burst ahead of it. Called just
   // after a rising edge and returns just after the edge that accepted it.
   task automatic send_byte(logic [BYTE_WIDTH-1:0] value, logic last);
      int gap;
      if (send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
         gap = $urandom_range(1, 12);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.frame_byte   <= value;
      req_bus.end_of_frame <= last;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      sb.note_byte(value, last);
      items_sent++;
   endtask

   task automatic send_frame(frame_bytes_type frame);
      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
   endtask

   // Holds the sender off until every pending status has come back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Puts the start flags, checksum and end flag in place where the
   // frame is long enough to hold them.
   function automatic void seal_frame(ref frame_bytes_type frame);
      int                    len;
      logic [BYTE_WIDTH-1:0] sum;
      len = frame.size();
      if (len < 8) return;
      frame[FIRST_FLAG_POS]  = START_FLAG;
      frame[SECOND_FLAG_POS] = START_FLAG;
      sum = '0;
      for (int i = 0; i < len - 2; i++) sum = sum + frame[i];
      frame[len-2] = sum;
      frame[len-1] = END_FLAG;
   endfunction

   function automatic frame_bytes_type random_frame(int len, bit sealed);
      frame_bytes_type frame;
      for (int i = 0; i < len; i++) frame.push_back(8'($urandom_range(0, 255)));
      if (sealed) seal_frame(frame);
      return frame;
   endfunction

   // Stimulus.
   initial begin
      frame_bytes_type frame;
      int              frame_count;
      int              kind;
      int              len;
      int              pos;

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.frame_byte   = '0;
      req_bus.end_of_frame = 1'b0;
      rsp_bus.ready        = 1'b0;
      items_sent           = 0;
      send_gap_odds        = 0;
      stall_odds           = 0;
      stall_left           = 0;
      frame_count          = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: a lone final byte, a minimum-length good frame with
      // all-zero and all-one payload bytes, and a frame one byte too short.
      send_byte(8'hFF, 1'b1);
      frame = {8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
               8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};
      seal_frame(frame);
      send_frame(frame);
      send_frame(random_frame(MIN_LEN - 1, 1'b1));
      drain_results();

      // Random frames, about half of them well formed.
      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent > TOTAL_ITEMS - QUIET_TAIL) begin
            send_gap_odds = 0;
            stall_odds    = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
               0: send_gap_odds = 0;
               1: send_gap_odds = 3;
               default: send_gap_odds = 10;
            endcase
            case ($urandom_range(0, 2))
               0: stall_odds = 0;
               1: stall_odds = 2;
               default: stall_odds = 6;
            endcase
         end

         frame_count++;
         kind = $urandom_range(0, 99);
         len  = $urandom_range(MIN_LEN, 40);
         if (frame_count == 5) begin
            // Longest legal frame.
            frame = random_frame(MAX_LEN, 1'b1);
         end else if (frame_count == 9) begin
            // Overlong frame whose count saturates.
            frame = random_frame(MAX_LEN + 2 + $urandom_range(0, 8), 1'b1);
         end else if (kind < 50) begin
            frame = random_frame(len, 1'b1);
         end else if (kind < 65) begin
            // Checksum byte off by a nonzero pattern.
            frame = random_frame(len, 1'b1);
            frame[len-2] = frame[len-2] ^ 8'($urandom_range(1, 255));
         end else if (kind < 80) begin
            // One of the flag bytes damaged.
            frame = random_frame(len, 1'b1);
            case ($urandom_range(0, 2))
               0: pos = FIRST_FLAG_POS;
               1: pos = SECOND_FLAG_POS;
               default: pos = len - 1;
            endcase
            frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
         end else if (kind < 90) begin
            // Too short.
            frame = random_frame($urandom_range(1, MIN_LEN - 1),
                                 1'($urandom_range(0, 1)));
         end else if (kind < 92) begin
            // Just past the maximum.
            frame = random_frame(MAX_LEN + 1 + $urandom_range(0, 3), 1'b1);
         end else begin
            frame = random_frame($urandom_range(1, 40), 1'b0);
         end
         send_frame(frame);

         if (frame_count == 3 || $urandom_range(0, 15) == 0) drain_results();
      end

      // Wind down.
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
src/mfc_pkg.sv
src/mfc_channels.sv
src/meter_frame_checker.sv
tb/meter_frame_checker_tb.sv
